/* rtl/tally_list_to_mask_parser_unit_assert.svh */
// Assertion macros for the tally list to mask parser.
`ifndef TALLY_LIST_TO_MASK_PARSER_UNIT_ASSERT_SVH
`define TALLY_LIST_TO_MASK_PARSER_UNIT_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define TLMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TLMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tlmp_pkg.sv */
// Shared types, constants and mask helpers for the tally list to mask parser.
package tlmp_pkg;

    localparam int MASK_W          = 64;
    localparam int CNT_W           = 7;   // holds 0 .. MASK_W
    localparam int NUM_TALLIES_DEF = 64;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        CK_OTHER,
        CK_DIGIT,
        CK_COMMA,
        CK_HYPHEN,
        CK_LBRACE,
        CK_RBRACE,
        CK_SLASH
    } char_kind_t;

    function automatic char_kind_t char_kind(input logic [7:0] ch);
        char_kind_t k;
        unique case (ch) inside
            [CH_ZERO:CH_NINE]: k = CK_DIGIT;
            CH_COMMA:          k = CK_COMMA;
            CH_HYPHEN:         k = CK_HYPHEN;
            CH_LBRACE:         k = CK_LBRACE;
            CH_RBRACE:         k = CK_RBRACE;
            CH_SLASH:          k = CK_SLASH;
            default:           k = CK_OTHER;
        endcase
        return k;
    endfunction

    // Bits 0 .. k-1 set, k from 0 to MASK_W.
    function automatic logic [MASK_W-1:0] low_ones(input logic [CNT_W-1:0] k);
        logic [MASK_W-1:0] m;
        if (k >= CNT_W'(MASK_W))
            m = '1;
        else
            m = (MASK_W'(1) << k) - MASK_W'(1);
        return m;
    endfunction

endpackage

/* rtl/tlmp_step.sv */
// Per-character state update and end-of-address mask completion.
module tlmp_step
    import tlmp_pkg::*;
#(
    parameter int NUM_TALLIES = NUM_TALLIES_DEF,
    parameter int NUM_W       = $clog2(NUM_TALLIES + 2)
)
(
    input  logic [7:0]        char_code,
    input  logic [NUM_W-1:0]  cur,
    input  logic [NUM_W-1:0]  start,
    input  logic              active,
    input  logic [MASK_W-1:0] mask,
    output logic [NUM_W-1:0]  cur_next,
    output logic [NUM_W-1:0]  start_next,
    output logic              active_next,
    output logic [MASK_W-1:0] mask_next,
    output logic [MASK_W-1:0] final_mask
);

    localparam int WIDE_W = NUM_W + 4;
    localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(NUM_TALLIES);
    localparam logic [NUM_W-1:0] NUM_SAT = NUM_W'(NUM_TALLIES + 1);

    function automatic logic is_valid(input logic [NUM_W-1:0] n);
        return (n != '0) && (n <= NUM_MAX);
    endfunction

    function automatic logic [MASK_W-1:0] single_bit(input logic [NUM_W-1:0] n);
        return MASK_W'(1) << (n - NUM_W'(1));
    endfunction

    // lo..hi inclusive, hi clipped at the tally count
    function automatic logic [MASK_W-1:0] fill_range(input logic [NUM_W-1:0] lo,
                                                     input logic [NUM_W-1:0] hi);
        logic [NUM_W-1:0]  hc;
        logic [MASK_W-1:0] m;
        hc = (hi > NUM_MAX) ? NUM_MAX : hi;
        if (lo == '0 || lo > hc)
            m = '0;
        else
            m = low_ones(CNT_W'(hc)) & ~low_ones(CNT_W'(lo - NUM_W'(1)));
        return m;
    endfunction

    char_kind_t        kind;
    logic [WIDE_W-1:0] cur_x;
    logic [WIDE_W-1:0] acc;

    assign kind  = char_kind(char_code);
    assign cur_x = WIDE_W'(cur);
    assign acc   = (cur_x << 3) + (cur_x << 1) + WIDE_W'(char_code[3:0]);

    always_comb
    begin
        cur_next    = cur;
        start_next  = start;
        active_next = active;
        mask_next   = mask;
        case (kind)
            CK_DIGIT:
            begin
                cur_next = (acc > WIDE_W'(NUM_SAT)) ? NUM_SAT : acc[NUM_W-1:0];
            end
            CK_COMMA:
            begin
                if (is_valid(cur))
                    mask_next = mask | single_bit(cur);
                cur_next    = '0;
                active_next = 1'b0;
            end
            CK_HYPHEN:
            begin
                if (is_valid(cur))
                begin
                    start_next  = cur;
                    active_next = 1'b1;
                    cur_next    = '0;
                end
            end
            CK_LBRACE:
            begin
                start_next  = cur;
                cur_next    = '0;
                active_next = 1'b1;
            end
            CK_RBRACE:
            begin
                if (start != '0 && cur > start)
                    mask_next = mask | fill_range(start, cur);
                cur_next    = '0;
                start_next  = '0;
                active_next = 1'b0;
            end
            CK_SLASH:
            begin
                if (is_valid(cur))
                    mask_next = mask | single_bit(cur);
                cur_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Close out a pending number or range after this character.
    always_comb
    begin
        final_mask = mask_next;
        if (is_valid(cur_next))
        begin
            if (active_next && start_next != '0)
                final_mask = mask_next | fill_range(start_next, cur_next);
            else
                final_mask = mask_next | single_bit(cur_next);
        end
    end

endmodule

/* rtl/tally_list_to_mask_parser_unit.sv */
// Top level of the tally list to mask parser.
// Takes one address character per beat and emits a 64-bit tally mask on the
// beat flagged is_last. Each character is registered, then handled
// combinationally against the parse state, so a new character is taken each
// cycle unless a last character is stalled: throughput is one character per
// clock while nothing stalls. The last character passes the input register,
// then its mask is written to the output register. A finished mask waits
// there; characters keep flowing while it waits, and only a further last
// character stalls until the mask is taken. No mask appears for other beats.
`include "tally_list_to_mask_parser_unit_assert.svh"

module tally_list_to_mask_parser_unit
    import tlmp_pkg::*;
#(
    parameter int NUM_TALLIES = NUM_TALLIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MASK_W-1:0] tally_mask
);

    localparam int NUM_W = $clog2(NUM_TALLIES + 2);

    logic              s1_valid_reg;
    logic [7:0]        s1_char_reg;
    logic              s1_last_reg;
    logic              s1_fire;
    logic              out_free;

    logic [NUM_W-1:0]  cur_reg;
    logic [NUM_W-1:0]  start_reg;
    logic              active_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [NUM_W-1:0]  cur_next;
    logic [NUM_W-1:0]  start_next;
    logic              active_next;
    logic [MASK_W-1:0] mask_next;
    logic [MASK_W-1:0] final_mask;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MASK_W-1:0] tally_mask_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= is_last;
        end
    end

    tlmp_step #(
        .NUM_TALLIES (NUM_TALLIES),
        .NUM_W       (NUM_W)
    ) u_step (
        .char_code   (s1_char_reg),
        .cur         (cur_reg),
        .start       (start_reg),
        .active      (active_reg),
        .mask        (mask_reg),
        .cur_next    (cur_next),
        .start_next  (start_next),
        .active_next (active_next),
        .mask_next   (mask_next),
        .final_mask  (final_mask)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            start_reg  <= '0;
            active_reg <= 1'b0;
            mask_reg   <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                cur_reg    <= '0;
                start_reg  <= '0;
                active_reg <= 1'b0;
                mask_reg   <= '0;
            end
            else
            begin
                cur_reg    <= cur_next;
                start_reg  <= start_next;
                active_reg <= active_next;
                mask_reg   <= mask_next;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
            tally_mask_reg <= final_mask;
    end

    assign out_valid  = out_valid_reg;
    assign tally_mask = tally_mask_reg;

    `TLMP_ASSERT_ALWAYS(a_cur_range, cur_reg <= NUM_W'(NUM_TALLIES + 1),
        "parse number beyond saturation value")
    `TLMP_ASSERT_ALWAYS(a_start_range, start_reg <= NUM_W'(NUM_TALLIES + 1),
        "range start beyond saturation value")
    `TLMP_ASSERT(a_clear_after_last,
        (s1_fire && s1_last_reg) |=> (cur_reg == '0 && !active_reg && mask_reg == '0),
        "parse state not cleared after last beat")
    `TLMP_ASSERT(a_mask_in_range, out_valid |-> ((tally_mask >> NUM_TALLIES) == '0),
        "mask bit set above tally count")

endmodule
